>>> sv/ecu_pkg.sv
package ecu_pkg;

    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [3:0] {
        CRV_LINEAR       = 4'd0,
        CRV_SMOOTHSTEP   = 4'd1,
        CRV_EASE_IN      = 4'd2,
        CRV_EASE_OUT     = 4'd3,
        CRV_SMOOTHERSTEP = 4'd4,
        CRV_EXPO         = 4'd5,
        CRV_CIRC         = 4'd6,
        CRV_CUBIC        = 4'd7,
        CRV_INSTANT      = 4'd8
    } curve_t;

    // q30 constants 2^(-2^-k), k = 1..24, each the floor square root of the previous one
    function automatic logic [30:0] exp_const(input int k);
        logic [63:0] c;
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        c = 64'd1 << 29;
        for (int i = 1; i <= 24; i++)
        begin
            if (i <= k)
            begin
                v = c << 30;
                r = '0;
                b = 64'd1 << 62;
                for (int j = 0; j < 32; j++)
                begin
                    if (v >= r + b)
                    begin
                        v = v - (r + b);
                        r = (r >> 1) + b;
                    end
                    else
                    begin
                        r = r >> 1;
                    end
                    b = b >> 2;
                end
                c = r;
            end
        end
        return c[30:0];
    endfunction

endpackage

>>> sv/ecu_if.sv
interface ecu_in_if #(parameter int FB = 16);
    logic                valid;
    logic                ready;
    logic [3:0]          cmd;
    logic signed [FB+1:0] progress;
    modport source (output valid, cmd, progress, input ready);
    modport sink (input valid, cmd, progress, output ready);
endinterface

interface ecu_out_if #(parameter int FB = 16);
    logic          valid;
    logic          ready;
    logic [FB:0]   eased;
    modport source (output valid, eased, input ready);
    modport sink (input valid, eased, output ready);
endinterface

>>> sv/easing_curve_unit_top.sv
// easing curve unit
// in: word of cmd (curve code) and progress (signed, FRAC_BITS fraction bits)
// out: one word per input, eased value 0..1 with FRAC_BITS fraction bits
// progress is clamped to 0..1; codes 9..15 act as linear
// the datapath is a fixed pipeline of NSTG register stages; the exponential
// curve walks its fraction bits through one multiply per stage, and the
// circular curve resolves one root bit per stage, so the depth is
// FRAC_BITS+5 stages
// throughput is one word per cycle in steady state while the receiver keeps ready high
// all stages advance together; when the output stage is full and the receiver
// holds ready low the whole pipeline holds, and in.ready is high whenever the
// output stage is empty or being taken, so nothing is lost or repeated
// reset clears all stage valid bits; the stage data registers are not reset
// results leave in the order their inputs came in
module easing_curve_unit_top
    import ecu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    ecu_in_if.sink    in_ch,
    ecu_out_if.source out_ch
);

    localparam int FB   = FRAC_BITS;
    localparam int NSTG = FB + 5;
    localparam int SQW  = FB + 2;
    localparam int RW   = 2 * SQW;
    localparam logic [FB+1:0] ONE = (FB+2)'(1) << FB;

    typedef struct packed {
        logic [3:0]    cmd;
        logic [FB:0]   t;
        logic [FB+1:0] a;
        logic [FB+1:0] b;
        logic [FB+1:0] c;
        logic [FB+3:0] e;
        logic [30:0]   acc;
        logic [RW-1:0] rem;
        logic [SQW-1:0] root;
        logic          flip;
    } stg_t;

    stg_t                stg_reg [NSTG];
    stg_t                stg_next [NSTG];
    logic [NSTG-1:0]     vld_reg;
    logic                adv;

    assign adv          = !vld_reg[NSTG-1] || out_ch.ready;
    assign in_ch.ready  = adv;
    assign out_ch.valid = vld_reg[NSTG-1];
    assign out_ch.eased = stg_reg[NSTG-1].a[FB:0];

    function automatic logic [FB+1:0] fxm(input logic [FB+1:0] x, input logic [FB+1:0] y);
        logic [2*FB+4:0] p;
        p = (2*FB+5)'(x) * (2*FB+5)'(y) + ((2*FB+5)'(1) << (FB-1));
        return p[2*FB+1:FB];
    endfunction

    function automatic logic [30:0] q30m(input logic [30:0] x, input logic [30:0] y);
        logic [61:0] p;
        p = 62'(x) * 62'(y) + (62'(1) << 29);
        return p[60:30];
    endfunction

    // stage 0: clamp and setup
    always_comb
    begin
        logic [FB+1:0] p;
        logic [FB:0]   t;
        logic [FB+5:0] x;
        p = in_ch.progress;
        if (p[FB+1])
            t = '0;
        else if (p > ONE)
            t = ONE[FB:0];
        else
            t = p[FB:0];
        x = (FB+6)'(t) * (FB+6)'(10);
        stg_next[0]      = '0;
        stg_next[0].cmd  = in_ch.cmd;
        stg_next[0].t    = t;
        stg_next[0].acc  = 31'(1) << 30;
        stg_next[0].e    = x[FB+3:0];
        stg_next[0].rem  = RW'(t) * RW'(ONE + ONE - (FB+2)'(t));
        stg_next[0].flip = (t >= (ONE >> 1));
        stg_next[0].a    = stg_next[0].flip ? ((ONE << 1) - ((FB+2)'(t) << 1))
                                            : ((FB+2)'(t) << 1);
    end

    // stages 1..NSTG-1: root bits, exp multiplies, polynomial steps, final curve select
    for (genvar g = 1; g < NSTG; g++)
    begin : g_stage
        localparam int SB = (g <= SQW) ? SQW - g : 0;
        localparam int EB = (g <= FB) ? FB - g : 0;
        localparam logic [30:0] KC = exp_const(g);

        always_comb
        begin
            stg_t s;
            s = stg_reg[g-1];
            if (g <= SQW)
            begin
                logic [RW-1:0] trial;
                trial = (RW'(s.root) << (2 * SB + 2)) | (RW'(1) << (2 * SB));
                if (s.rem >= trial)
                begin
                    s.rem  = s.rem - trial;
                    s.root = {s.root[SQW-2:0], 1'b1};
                end
                else
                begin
                    s.root = {s.root[SQW-2:0], 1'b0};
                end
            end
            if (g <= FB && s.e[EB])
                s.acc = q30m(s.acc, KC);
            unique case (g)
                1:
                begin
                    s.b = fxm((FB+2)'(s.t), (FB+2)'(s.t));
                    s.c = fxm(s.a, s.a);
                end
                2:
                begin
                    s.c = fxm(s.c, s.a);
                    s.a = s.b;
                    s.b = fxm(s.b, (FB+2)'(s.t));
                end
                default:
                begin
                end
            endcase
            if (g == NSTG - 1)
            begin
                logic [FB+3:0]   sh;
                logic [30:0]     ev;
                logic [FB+5:0]   pl;
                logic [2*FB+7:0] pm;
                logic [FB+7:0]   pv;
                logic [FB+1:0]   hc;
                logic [FB+1:0]   u;
                logic [FB+1:0]   r;
                u  = ONE - (FB+2)'(s.t);
                sh = (FB+4)'(s.e[FB+3:FB]) + (FB+4)'(30 - FB);
                ev = (s.acc + (31'(1) << (sh - 1))) >> sh;
                hc = (s.c + (FB+2)'(1)) >> 1;
                pl = (FB+6)'(ONE) * (FB+6)'(10) + (FB+6)'(s.a) * (FB+6)'(6)
                     - (FB+6)'(s.t) * (FB+6)'(15);
                pm = (2*FB+8)'(s.b) * (2*FB+8)'(pl) + ((2*FB+8)'(1) << (FB-1));
                pv = pm[2*FB+7:FB];
                unique case (s.cmd)
                    CRV_SMOOTHSTEP:   r = fxm(s.a, (ONE << 1) + ONE - ((FB+2)'(s.t) << 1));
                    CRV_EASE_IN:      r = s.a;
                    CRV_EASE_OUT:     r = ONE - fxm(u, u);
                    CRV_SMOOTHERSTEP: r = (pv > (FB+8)'(ONE)) ? ONE : pv[FB+1:0];
                    CRV_EXPO:         r = (s.t >= ONE[FB:0]) ? ONE :
                                          ((31'(ONE) <= ev) ? '0 : ONE - (FB+2)'(ev));
                    CRV_CIRC:         r = s.root;
                    CRV_CUBIC:        r = s.flip ? ((hc >= ONE) ? '0 : ONE - hc) : hc;
                    CRV_INSTANT:      r = (s.t != '0) ? ONE : '0;
                    default:          r = (FB+2)'(s.t);
                endcase
                s.a = (r > ONE) ? ONE : r;
            end
            stg_next[g] = s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], in_ch.valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            for (int i = 0; i < NSTG; i++)
                stg_reg[i] <= stg_next[i];
    end

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.eased))
        else $error("output changed under stall");
    a_rng: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_ch.eased <= ONE[FB:0])
        else $error("eased above one");
    a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready)
        else $error("stalled with empty output");

endmodule

>>> dv/tb_top.sv
module tb_top;
    import ecu_pkg::*;

    localparam int FB = FRAC_BITS_DEF;
    localparam longint ONE = 64'd1 << FB;

    class eased_board;
        logic [FB:0] pending[$];
        int errors;

        function automatic longint fmul(longint a, longint b);
            return (a * b + (ONE >> 1)) >>> FB;
        endfunction

        function automatic longint root_floor(longint v);
            longint res;
            longint bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv = bitv >> 2;
            while (bitv != 0)
            begin
                if (v >= res + bitv)
                begin
                    v = v - (res + bitv);
                    res = (res >> 1) + bitv;
                end
                else
                begin
                    res = res >> 1;
                end
                bitv = bitv >> 2;
            end
            return res;
        endfunction

        function automatic longint half_cube(longint v);
            return (fmul(fmul(v, v), v) + 1) >> 1;
        endfunction

        function automatic longint expo_out(longint t);
            longint x;
            longint n;
            longint f;
            longint acc;
            longint c;
            longint e;
            longint s;
            if (t >= ONE)
                return ONE;
            x = 10 * t;
            n = x >> FB;
            f = x & (ONE - 1);
            acc = 64'd1 << 30;
            c = 64'd1 << 29;
            for (int k = 1; k <= FB; k++)
            begin
                c = root_floor(c << 30);
                if ((f >> (FB - k)) & 1)
                    acc = (acc * c + (64'd1 << 29)) >> 30;
            end
            s = n + 30 - FB;
            e = (acc + (64'd1 << (s - 1))) >> s;
            return e >= ONE ? 0 : ONE - e;
        endfunction

        function automatic logic [FB:0] ease(logic [3:0] code, logic signed [FB+1:0] prog);
            longint t;
            longint r;
            longint s;
            longint u;
            if (prog < 0)
                t = 0;
            else
                t = (prog > ONE) ? ONE : longint'(prog);
            case (code)
                CRV_SMOOTHSTEP:
                begin
                    s = fmul(t, t);
                    r = fmul(s, 3 * ONE - 2 * t);
                end
                CRV_EASE_IN: r = fmul(t, t);
                CRV_EASE_OUT:
                begin
                    s = fmul(ONE - t, ONE - t);
                    r = s >= ONE ? 0 : ONE - s;
                end
                CRV_SMOOTHERSTEP:
                begin
                    s = fmul(t, t);
                    u = 10 * ONE + 6 * s - 15 * t;
                    r = fmul(fmul(s, t), u);
                end
                CRV_EXPO: r = expo_out(t);
                CRV_CIRC: r = root_floor(t * (2 * ONE - t));
                CRV_CUBIC:
                begin
                    if (t < (ONE >> 1))
                        r = half_cube(2 * t);
                    else
                    begin
                        s = half_cube(2 * ONE - 2 * t);
                        r = s >= ONE ? 0 : ONE - s;
                    end
                end
                CRV_INSTANT: r = t > 0 ? ONE : 0;
                default: r = t;
            endcase
            if (r > ONE)
                r = ONE;
            return r[FB:0];
        endfunction

        function void note_input(logic [3:0] code, logic signed [FB+1:0] prog);
            pending.push_back(ease(code, prog));
        endfunction

        function void check_result(logic [FB:0] got);
            logic [FB:0] want;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected word eased=%0d", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                $display("%0t: eased mismatch expected %0d actual %0d", $time, want, got);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    eased_board board;
    bit stim_done;

    ecu_in_if #(.FB(FB)) in_ch();
    ecu_out_if #(.FB(FB)) out_ch();

    easing_curve_unit_top #(.FRAC_BITS(FB)) u_top
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_ch(in_ch.sink),
        .out_ch(out_ch.source)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 60)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic send_word(logic [3:0] code, logic signed [FB+1:0] prog, int gap);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.cmd <= code;
        in_ch.progress <= prog;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        board.note_input(code, prog);
        @(negedge clk);
    endtask

    task automatic random_word(bit burst);
        logic [3:0] code;
        logic signed [FB+1:0] prog;
        int p;
        code = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 3) != 0)
            code = 4'($urandom_range(0, 8));
        p = $urandom_range(0, 9);
        if (p < 7)
            prog = (FB+2)'($urandom_range(0, ONE));
        else if (p < 8)
            prog = (FB+2)'($urandom());
        else if (p < 9)
            prog = (FB+2)'(ONE - 2 + $urandom_range(0, 4));
        else
            prog = (FB+2)'($urandom_range(0, 3) - 1);
        send_word(code, prog, burst ? 0 : gap_len());
    endtask

    initial
    begin
        logic signed [FB+1:0] edge_prog[8];
        board = new();
        stim_done = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.cmd = '0;
        in_ch.progress = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        edge_prog = '{-131072, -1, 0, 1, 32767, 32768, 65536, 131071};
        for (int c = 0; c <= 8; c++)
            send_word(4'(c), edge_prog[c % 8], 0);
        for (int i = 0; i < 8; i++)
            send_word(CRV_EXPO, edge_prog[i], gap_len());
        send_word(4'd15, 18'sd40000, 0);
        send_word(4'd9, 18'sd65535, 0);
        send_word(CRV_CIRC, 18'sd65535, 0);
        send_word(CRV_CUBIC, 18'sd32769, 0);
        for (int i = 0; i < 1350; i++)
        begin
            random_word(i % 200 < 50);
            if (i == 700)
            begin
                in_ch.valid <= 1'b0;
                while (board.pending.size() != 0)
                    @(negedge clk);
            end
        end
        in_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < 70)
                out_ch.ready <= 1'b1;
            else
            begin
                out_ch.ready <= 1'b0;
                repeat (gap_len() + 1) @(negedge clk);
                out_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
            board.check_result(out_ch.eased);
    end

    initial
    begin
        wait (stim_done);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (FB + 40) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #10000000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
